FILE: src/idq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idq_pkg: shared types and constants of the indexed deque store
// Field widths, word layouts, request and status codes, and the command
// that the control logic broadcasts to the row of storage cells.
// ----------------------------------------------------------------------------
package idq_pkg;

    localparam int unsigned DEFAULT_DEPTH = 64;
    localparam int unsigned MAX_DEPTH     = 4096;

    localparam int unsigned OP_W     = 4;
    localparam int unsigned POS_W    = 7;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned LEN_W    = 7;
    localparam int unsigned COUNT_W  = 7;
    localparam int unsigned STATUS_W = 2;

    // Index width that covers every legal depth and every 7-bit field.
    localparam int unsigned IDX_W = $clog2(MAX_DEPTH + 1);

    localparam int unsigned IN_OP_LSB   = 0;
    localparam int unsigned IN_POS_LSB  = IN_OP_LSB + OP_W;
    localparam int unsigned IN_WORD_LSB = IN_POS_LSB + POS_W;
    localparam int unsigned IN_LEN_LSB  = IN_WORD_LSB + WORD_W;
    localparam int unsigned IN_BITS     = IN_LEN_LSB + LEN_W;
    localparam int unsigned IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

    localparam int unsigned OUT_WORD_LSB   = 0;
    localparam int unsigned OUT_COUNT_LSB  = OUT_WORD_LSB + WORD_W;
    localparam int unsigned OUT_EMPTY_LSB  = OUT_COUNT_LSB + COUNT_W;
    localparam int unsigned OUT_FRONT_LSB  = OUT_EMPTY_LSB + 1;
    localparam int unsigned OUT_BACK_LSB   = OUT_FRONT_LSB + WORD_W;
    localparam int unsigned OUT_STATUS_LSB = OUT_BACK_LSB + WORD_W;
    localparam int unsigned OUT_BITS       = OUT_STATUS_LSB + STATUS_W;
    localparam int unsigned OUT_TDATA_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 4'd0,
        OP_PUSH_FRONT = 4'd1,
        OP_POP_BACK   = 4'd2,
        OP_POP_FRONT  = 4'd3,
        OP_INSERT     = 4'd4,
        OP_ERASE      = 4'd5,
        OP_READ       = 4'd6,
        OP_RESIZE     = 4'd7,
        OP_CLEAR      = 4'd8
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_ERASE  = 2'd2,
        CMD_FILL   = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [IDX_W-1:0]   index;
        logic [IDX_W-1:0]   count;
        logic [IDX_W-1:0]   limit;
        logic [WORD_W-1:0]  word;
        logic [IDX_W-1:0]   rd_index;
    } cmd_t;

endpackage

FILE: src/indexed_deque_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_deque_store: bounded deque with indexed insert, erase and read
// Ordered store of up to DEPTH signed 32-bit words in a row of shifting cells.
// ----------------------------------------------------------------------------
// Requests arrive as words on the s_axis channel: push or pop at either end,
// insert, erase or read at an index, resize with a fill value, or clear.
// Every request yields exactly one word on the m_axis channel with the
// popped, erased or read value, the new count, an empty flag, the front and back
// entries and a status code. Errors leave the store untouched.
// The accepting edge registers the request; then in S_EXEC all cells shift or
// load in parallel while the shared read tap picks the leaving entry, and in
// S_FINISH the same tap reads the new back entry into the output register.
// The next request is accepted only once the block is back in S_IDLE, so it
// takes no new request before the last one has reached the output register.
// The output register holds a finished result while m_axis_tready is low;
// one further request may be accepted and processed meanwhile, and it waits
// in its final cycle until the output register is free.
// Reset empties the store and drops any pending result. Cell contents are not
// cleared; only entries below the count are ever visible.
// ----------------------------------------------------------------------------
module indexed_deque_store #(
    parameter int unsigned DEPTH = idq_pkg::DEFAULT_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // operation[3:0], position[10:4], word_in[42:11], new_length[49:43], zero pad
    input  logic [idq_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // word_out[31:0], count[38:32], is_empty[39], front_word[71:40],
    // back_word[103:72], status[105:104], zero pad
    output logic [idq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [idq_pkg::IDX_W-1:0] DEPTH_X = idq_pkg::IDX_W'(DEPTH);
    localparam int unsigned PAD_W = idq_pkg::OUT_TDATA_W - idq_pkg::OUT_BITS;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EXEC   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t                             state_reg;
    state_t                             state_next;
    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;

    idq_pkg::op_t                       op_reg;
    logic [idq_pkg::POS_W-1:0]          pos_reg;
    logic [idq_pkg::WORD_W-1:0]         win_reg;
    logic [idq_pkg::LEN_W-1:0]          len_reg;
    logic [idq_pkg::WORD_W-1:0]         res_word_reg;
    logic [idq_pkg::WORD_W-1:0]         res_word_next;
    idq_pkg::status_t                   res_status_reg;
    idq_pkg::status_t                   res_status_next;
    logic [idq_pkg::OUT_TDATA_W-1:0]    out_data_reg;
    logic [idq_pkg::OUT_TDATA_W-1:0]    out_data_next;

    idq_pkg::cmd_t                      cmd;
    logic [idq_pkg::WORD_W-1:0]         rd_word;
    logic [idq_pkg::WORD_W-1:0]         first_word;

    logic [idq_pkg::IDX_W-1:0]          cnt_x;
    logic [idq_pkg::IDX_W-1:0]          pos_x;
    logic [idq_pkg::IDX_W-1:0]          len_x;
    logic                               is_full;
    logic                               is_zero;
    logic                               take_word;
    logic                               accept;
    logic                               load_out;
    logic                               empty_now;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    assign cnt_x   = idq_pkg::IDX_W'(count_reg);
    assign pos_x   = idq_pkg::IDX_W'(pos_reg);
    assign len_x   = idq_pkg::IDX_W'(len_reg);
    assign is_full = (cnt_x >= DEPTH_X);
    assign is_zero = (count_reg == '0);

    always_comb
    begin
        cmd.kind        = idq_pkg::CMD_HOLD;
        cmd.index       = '0;
        cmd.count       = cnt_x;
        cmd.limit       = len_x;
        cmd.word        = win_reg;
        cmd.rd_index    = pos_x;
        count_next      = count_reg;
        res_status_next = idq_pkg::ST_OK;
        take_word       = 1'b0;

        if (state_reg == S_EXEC)
        begin
            unique case (op_reg)
                idq_pkg::OP_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        res_status_next = idq_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.kind   = idq_pkg::CMD_INSERT;
                        cmd.index  = cnt_x;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                idq_pkg::OP_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        res_status_next = idq_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.kind   = idq_pkg::CMD_INSERT;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                idq_pkg::OP_POP_BACK:
                begin
                    cmd.rd_index = cnt_x - idq_pkg::IDX_W'(1);
                    if (is_zero)
                    begin
                        res_status_next = idq_pkg::ST_UNDER;
                    end
                    else
                    begin
                        take_word  = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                idq_pkg::OP_POP_FRONT:
                begin
                    cmd.rd_index = '0;
                    if (is_zero)
                    begin
                        res_status_next = idq_pkg::ST_UNDER;
                    end
                    else
                    begin
                        take_word  = 1'b1;
                        cmd.kind   = idq_pkg::CMD_ERASE;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                idq_pkg::OP_INSERT:
                begin
                    if (pos_x > cnt_x)
                    begin
                        res_status_next = idq_pkg::ST_RANGE;
                    end
                    else if (is_full)
                    begin
                        res_status_next = idq_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.kind   = idq_pkg::CMD_INSERT;
                        cmd.index  = pos_x;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                idq_pkg::OP_ERASE:
                begin
                    if (is_zero)
                    begin
                        res_status_next = idq_pkg::ST_UNDER;
                    end
                    else if (pos_x >= cnt_x)
                    begin
                        res_status_next = idq_pkg::ST_RANGE;
                    end
                    else
                    begin
                        take_word  = 1'b1;
                        cmd.kind   = idq_pkg::CMD_ERASE;
                        cmd.index  = pos_x;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                idq_pkg::OP_READ:
                begin
                    if (pos_x >= cnt_x)
                    begin
                        res_status_next = idq_pkg::ST_RANGE;
                    end
                    else
                    begin
                        take_word = 1'b1;
                    end
                end
                idq_pkg::OP_RESIZE:
                begin
                    if (len_x > DEPTH_X)
                    begin
                        res_status_next = idq_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.kind   = idq_pkg::CMD_FILL;
                        count_next = CNT_W'(len_x);
                    end
                end
                idq_pkg::OP_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
        else if (state_reg == S_FINISH)
        begin
            cmd.rd_index = cnt_x - idq_pkg::IDX_W'(1);
        end
    end

    assign res_word_next = take_word ? rd_word : '0;

    idq_chain #(
        .DEPTH (DEPTH)
    ) u_chain (
        .clk        (clk),
        .cmd        (cmd),
        .rd_word    (rd_word),
        .first_word (first_word)
    );

    assign load_out  = (state_reg == S_FINISH) && (!out_valid_reg || m_axis_tready);
    assign empty_now = is_zero;

    always_comb
    begin
        out_data_next = {
            {PAD_W{1'b0}},
            res_status_reg,
            (empty_now ? {idq_pkg::WORD_W{1'b0}} : rd_word),
            (empty_now ? {idq_pkg::WORD_W{1'b0}} : first_word),
            empty_now,
            idq_pkg::COUNT_W'(count_reg),
            res_word_reg
        };
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= idq_pkg::op_t'(s_axis_tdata[idq_pkg::IN_OP_LSB +: idq_pkg::OP_W]);
            pos_reg <= s_axis_tdata[idq_pkg::IN_POS_LSB +: idq_pkg::POS_W];
            win_reg <= s_axis_tdata[idq_pkg::IN_WORD_LSB +: idq_pkg::WORD_W];
            len_reg <= s_axis_tdata[idq_pkg::IN_LEN_LSB +: idq_pkg::LEN_W];
        end
        if (state_reg == S_EXEC)
        begin
            res_word_reg   <= res_word_next;
            res_status_reg <= res_status_next;
        end
        if (load_out)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

FILE: src/idq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idq_cell: one storage cell of the deque
// Holds one word and, on each broadcast command, keeps it, takes the word of
// its lower or upper neighbor, or loads the command word.
// ----------------------------------------------------------------------------
module idq_cell #(
    parameter int unsigned Idx = 0
) (
    input  logic                        clk,
    input  idq_pkg::cmd_t               cmd,
    input  logic [idq_pkg::WORD_W-1:0]  left_word,
    input  logic [idq_pkg::WORD_W-1:0]  right_word,
    output logic [idq_pkg::WORD_W-1:0]  word,
    output logic [idq_pkg::WORD_W-1:0]  tap
);

    localparam logic [idq_pkg::IDX_W-1:0] MY_IDX  = idq_pkg::IDX_W'(Idx);
    localparam logic [idq_pkg::IDX_W-1:0] MY_NEXT = idq_pkg::IDX_W'(Idx + 1);

    logic [idq_pkg::WORD_W-1:0] word_reg;
    logic [idq_pkg::WORD_W-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        unique case (cmd.kind)
            idq_pkg::CMD_HOLD:
            begin
                word_next = word_reg;
            end
            idq_pkg::CMD_INSERT:
            begin
                if (MY_IDX == cmd.index)
                begin
                    word_next = cmd.word;
                end
                else if (MY_IDX > cmd.index && MY_IDX <= cmd.count)
                begin
                    word_next = left_word;
                end
            end
            idq_pkg::CMD_ERASE:
            begin
                if (MY_IDX >= cmd.index && MY_NEXT < cmd.count)
                begin
                    word_next = right_word;
                end
            end
            idq_pkg::CMD_FILL:
            begin
                if (MY_IDX >= cmd.count && MY_IDX < cmd.limit)
                begin
                    word_next = cmd.word;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;
    assign tap  = (MY_IDX == cmd.rd_index) ? word_reg : '0;

endmodule

FILE: src/idq_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idq_chain: the row of storage cells
// Links every cell to its neighbors and merges the cell taps into one read
// word; also exposes the first cell.
// ----------------------------------------------------------------------------
module idq_chain #(
    parameter int unsigned DEPTH = idq_pkg::DEFAULT_DEPTH
) (
    input  logic                        clk,
    input  idq_pkg::cmd_t               cmd,
    output logic [idq_pkg::WORD_W-1:0]  rd_word,
    output logic [idq_pkg::WORD_W-1:0]  first_word
);

    logic [idq_pkg::WORD_W-1:0] cell_word [DEPTH];
    logic [idq_pkg::WORD_W-1:0] cell_tap  [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [idq_pkg::WORD_W-1:0] left_word;
        logic [idq_pkg::WORD_W-1:0] right_word;

        if (i == 0)
        begin : g_first
            assign left_word = '0;
        end
        else
        begin : g_mid_left
            assign left_word = cell_word[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_word = '0;
        end
        else
        begin : g_mid_right
            assign right_word = cell_word[i+1];
        end

        idq_cell #(
            .Idx (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .left_word  (left_word),
            .right_word (right_word),
            .word       (cell_word[i]),
            .tap        (cell_tap[i])
        );
    end

    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_word = rd_word | cell_tap[i];
        end
    end

    assign first_word = cell_word[0];

endmodule

FILE: src/idq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idq_checker: port-level checks of the indexed deque store
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module idq_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [idq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    logic                               out_empty;
    logic [idq_pkg::COUNT_W-1:0]        out_count;
    logic [idq_pkg::WORD_W-1:0]         out_word;
    logic [idq_pkg::WORD_W-1:0]         out_front;
    logic [idq_pkg::WORD_W-1:0]         out_back;
    logic [idq_pkg::STATUS_W-1:0]       out_status;

    assign out_empty  = m_axis_tdata[idq_pkg::OUT_EMPTY_LSB];
    assign out_count  = m_axis_tdata[idq_pkg::OUT_COUNT_LSB +: idq_pkg::COUNT_W];
    assign out_word   = m_axis_tdata[idq_pkg::OUT_WORD_LSB +: idq_pkg::WORD_W];
    assign out_front  = m_axis_tdata[idq_pkg::OUT_FRONT_LSB +: idq_pkg::WORD_W];
    assign out_back   = m_axis_tdata[idq_pkg::OUT_BACK_LSB +: idq_pkg::WORD_W];
    assign out_status = m_axis_tdata[idq_pkg::OUT_STATUS_LSB +: idq_pkg::STATUS_W];

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("Result word dropped while stalled.");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("Result word changed while stalled.");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_empty |->
            out_count == '0 && out_front == '0 && out_back == '0)
        else $error("Empty result shows a count or entries.");

    a_error_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_status != idq_pkg::ST_OK |-> out_word == '0)
        else $error("Failed request returned a word.");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("Result appeared one cycle after a request.");

endmodule

bind indexed_deque_store idq_checker u_idq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
